@@ rtl/mca_pkg.sv @@
`default_nettype none
package mca_pkg;

	localparam logic [3:0] ANY_MOD_MASK = 4'hF;

	localparam logic [2:0] KEY_CTRL  = 3'd1;
	localparam logic [2:0] KEY_SHIFT = 3'd2;
	localparam logic [2:0] KEY_ALT   = 3'd3;
	localparam logic [2:0] KEY_SUPER = 3'd4;

	typedef enum logic [1:0] {
		ACT_PRESS   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_ORPHAN  = 2'd2,
		ACT_SWITCH  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_FWD,
		OP_REPLAY,
		OP_CONSUME
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_TAIL
	} state_t;

	typedef struct packed {
		logic        pressed;
		logic [9:0]  key_code;
		logic [31:0] key_symbol;
		logic [31:0] modifiers;
		logic [20:0] code_point;
		logic [31:0] timestamp;
	} slot_t;

	typedef struct packed {
		action_t     action;
		logic [9:0]  key_code;
		logic [31:0] key_symbol;
		logic [31:0] modifiers;
		logic [20:0] code_point;
		logic [31:0] timestamp;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/mca_evt_if.sv @@
`default_nettype none
interface mca_evt_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [9:0]  key_code;
	logic [31:0] key_symbol;
	logic [31:0] event_modifiers;
	logic [20:0] code_point;
	logic [31:0] timestamp;
	logic [3:0]  held_modifiers;
	logic [2:0]  key_class;

	modport source (
		output valid, mode, key_code, key_symbol, event_modifiers, code_point, timestamp,
			held_modifiers, key_class,
		input  ready
	);
	modport sink (
		input  valid, mode, key_code, key_symbol, event_modifiers, code_point, timestamp,
			held_modifiers, key_class,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/mca_res_if.sv @@
`default_nettype none
interface mca_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  out_key_code;
	logic [31:0] out_key_symbol;
	logic [31:0] out_modifiers;
	logic [20:0] out_code_point;
	logic [31:0] out_timestamp;
	logic        last;

	modport source (
		output valid, action, out_key_code, out_key_symbol, out_modifiers, out_code_point,
			out_timestamp, last,
		input  ready
	);
	modport sink (
		input  valid, action, out_key_code, out_key_symbol, out_modifiers, out_code_point,
			out_timestamp, last,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/mca_slot_mem.sv @@
`default_nettype none
module mca_slot_mem #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire mca_pkg::slot_t           wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output mca_pkg::slot_t                rdata
);

	mca_pkg::slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/modifier_chord_arbiter.sv @@
// A forwarded event is registered on acceptance and presented from the tail state.
// Replay/consume: sweep of the slot memory (synchronous read), one slot per
// cycle unless a result stalls, then the tail result; no event is taken meanwhile.
// A buffered press or release leaves the arbiter idle and yields no result.
// Reset (arst_n low, async): idle, buffer empty, chord_mask = ctrl+shift.
// Slot memory has no reset; only written slots are read.
`default_nettype none
module modifier_chord_arbiter #(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	mca_evt_if.sink         evt,
	mca_res_if.source       res
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	logic [3:0]         chord_mask_q;
	logic               buffering_q;
	logic [CNT_W-1:0]   held_count_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_d;
	mca_pkg::op_t       op_q;
	mca_pkg::op_t       op;
	mca_pkg::state_t    state_q;
	mca_pkg::state_t    state_d;
	mca_pkg::slot_t     cur_q;
	mca_pkg::slot_t     in_slot;
	mca_pkg::slot_t     rd_slot;
	mca_pkg::res_t      out_q;
	mca_pkg::res_t      out_d;
	logic               out_valid_q;

	logic accept;
	logic out_free;
	logic advance;
	logic load_out;
	logic emit_need;
	logic last_slot;
	logic is_chord;
	logic forbid;
	logic full_held;
	logic do_write;

	assign in_slot = '{pressed: evt.mode, key_code: evt.key_code, key_symbol: evt.key_symbol,
		modifiers: evt.event_modifiers, code_point: evt.code_point, timestamp: evt.timestamp};

	always_comb begin
		unique case (evt.key_class)
			mca_pkg::KEY_CTRL:  is_chord = chord_mask_q[0];
			mca_pkg::KEY_SHIFT: is_chord = chord_mask_q[1];
			mca_pkg::KEY_ALT:   is_chord = chord_mask_q[2];
			mca_pkg::KEY_SUPER: is_chord = chord_mask_q[3];
			default:            is_chord = 1'b0;
		endcase
	end

	assign forbid    = |(evt.held_modifiers & (mca_pkg::ANY_MOD_MASK & ~chord_mask_q));
	assign full_held = (evt.held_modifiers & chord_mask_q) == chord_mask_q;

	always_comb begin
		priority if (!buffering_q) begin
			op = (evt.mode && is_chord && full_held && !forbid) ? mca_pkg::OP_PUSH
				: mca_pkg::OP_FWD;
		end else if (evt.mode) begin
			op = (!is_chord || forbid || held_count_q >= CNT_W'(BUFFER_DEPTH - 1))
				? mca_pkg::OP_REPLAY : mca_pkg::OP_PUSH;
		end else if (forbid) begin
			op = mca_pkg::OP_REPLAY;
		end else begin
			op = ((evt.held_modifiers & chord_mask_q) != 4'd0) ? mca_pkg::OP_PUSH
				: mca_pkg::OP_CONSUME;
		end
	end

	assign accept   = evt.valid && evt.ready;
	assign do_write = accept && (op == mca_pkg::OP_PUSH || op == mca_pkg::OP_CONSUME)
		&& held_count_q < CNT_W'(BUFFER_DEPTH);
	assign out_free = !out_valid_q || res.ready;
	assign emit_need = (op_q == mca_pkg::OP_REPLAY) || !rd_slot.pressed;
	assign last_slot = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign idx_d = accept ? '0 : (advance ? idx_q + IDX_W'(1) : idx_q);

	mca_slot_mem #(.DEPTH(BUFFER_DEPTH)) u_mem (
		.clk   (clk),
		.we    (do_write),
		.waddr (held_count_q[IDX_W-1:0]),
		.wdata (in_slot),
		.raddr (idx_d),
		.rdata (rd_slot)
	);

	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		load_out  = 1'b0;
		evt.ready = 1'b0;
		out_d     = '0;
		unique case (state_q)
			mca_pkg::ST_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid) begin
					unique case (op)
						mca_pkg::OP_PUSH: state_d = mca_pkg::ST_IDLE;
						mca_pkg::OP_FWD:  state_d = mca_pkg::ST_TAIL;
						default:          state_d = mca_pkg::ST_SWEEP;
					endcase
				end
			end
			mca_pkg::ST_SWEEP: begin
				if (!emit_need || out_free) begin
					advance  = 1'b1;
					load_out = emit_need;
					out_d = '{action: (op_q == mca_pkg::OP_REPLAY)
							? (rd_slot.pressed ? mca_pkg::ACT_PRESS : mca_pkg::ACT_RELEASE)
							: mca_pkg::ACT_ORPHAN,
						key_code: rd_slot.key_code, key_symbol: rd_slot.key_symbol,
						modifiers: rd_slot.modifiers, code_point: rd_slot.code_point,
						timestamp: rd_slot.timestamp, last: 1'b0};
					if (last_slot) begin
						state_d = mca_pkg::ST_TAIL;
					end
				end
			end
			mca_pkg::ST_TAIL: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = mca_pkg::ST_IDLE;
					if (op_q == mca_pkg::OP_CONSUME) begin
						out_d.action = mca_pkg::ACT_SWITCH;
						out_d.last   = 1'b1;
					end else begin
						out_d = '{action: cur_q.pressed ? mca_pkg::ACT_PRESS
								: mca_pkg::ACT_RELEASE,
							key_code: cur_q.key_code, key_symbol: cur_q.key_symbol,
							modifiers: cur_q.modifiers, code_point: cur_q.code_point,
							timestamp: cur_q.timestamp, last: 1'b1};
					end
				end
			end
			default: begin
				state_d = mca_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mca_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_mask_q <= 4'd3;
			buffering_q  <= 1'b0;
			held_count_q <= '0;
			out_valid_q  <= 1'b0;
			op_q         <= mca_pkg::OP_PUSH;
			count_q      <= '0;
			idx_q        <= '0;
		end else begin
			if (cfg_we) begin
				chord_mask_q <= cfg_wdata;
			end
			if (accept) begin
				op_q  <= op;
				idx_q <= '0;
				unique case (op)
					mca_pkg::OP_PUSH: begin
						buffering_q <= 1'b1;
						if (do_write) begin
							held_count_q <= held_count_q + CNT_W'(1);
						end
					end
					mca_pkg::OP_FWD: begin
					end
					mca_pkg::OP_REPLAY: begin
						count_q      <= held_count_q;
						held_count_q <= '0;
						buffering_q  <= 1'b0;
					end
					default: begin
						count_q      <= held_count_q + CNT_W'(do_write);
						held_count_q <= '0;
						buffering_q  <= 1'b0;
					end
				endcase
			end else if (advance) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= in_slot;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.action         = out_q.action;
	assign res.out_key_code   = out_q.key_code;
	assign res.out_key_symbol = out_q.key_symbol;
	assign res.out_modifiers  = out_q.modifiers;
	assign res.out_code_point = out_q.code_point;
	assign res.out_timestamp  = out_q.timestamp;
	assign res.last           = out_q.last;

endmodule
`default_nettype wire

@@ rtl/mca_checker.sv @@
`default_nettype none
module mca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        evt_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  res_action,
	input wire logic [9:0]  res_key_code,
	input wire logic [31:0] res_key_symbol,
	input wire logic [31:0] res_modifiers,
	input wire logic [20:0] res_code_point,
	input wire logic [31:0] res_timestamp,
	input wire logic        res_last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_action)
			&& $stable(res_key_code) && $stable(res_timestamp) && $stable(res_last))
		else $error("stalled result changed");

	// no new request taken mid-sequence
	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !evt_ready)
		else $error("input ready while result sequence open");

	a_switch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == mca_pkg::ACT_SWITCH |-> res_last && res_key_code == 10'd0
			&& res_key_symbol == 32'd0 && res_modifiers == 32'd0
			&& res_code_point == 21'd0 && res_timestamp == 32'd0)
		else $error("switch result malformed");

	a_orphan_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == mca_pkg::ACT_ORPHAN |-> !res_last)
		else $error("orphan release marked last");

endmodule

bind modifier_chord_arbiter mca_checker u_mca_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.evt_ready      (evt.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_action     (res.action),
	.res_key_code   (res.out_key_code),
	.res_key_symbol (res.out_key_symbol),
	.res_modifiers  (res.out_modifiers),
	.res_code_point (res.out_code_point),
	.res_timestamp  (res.out_timestamp),
	.res_last       (res.last)
);
`default_nettype wire
